// ===== design/cepc_pkg.sv =====
// shared types and constants of the coulomb exclusion pair correction block
package cepc_pkg;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned CHG_W    = 24;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned OUT_W    = 48;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    // register index of the mode register
    localparam logic REG_MODE = 1'b0;

    localparam logic MODE_FORCE     = 1'b0;
    localparam logic MODE_POTENTIAL = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]        home_index;
        logic [IDX_W-1:0]        partner_index;
        logic signed [POS_W-1:0] home_x;
        logic signed [POS_W-1:0] home_y;
        logic signed [POS_W-1:0] home_z;
        logic signed [CHG_W-1:0] home_charge;
        logic signed [POS_W-1:0] partner_x;
        logic signed [POS_W-1:0] partner_y;
        logic signed [POS_W-1:0] partner_z;
        logic signed [CHG_W-1:0] partner_charge;
        logic                    last_pair;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        target_index;
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic signed [OUT_W-1:0] potential;
        logic                    is_home_total;
        logic                    run_end;
    } out_word_t;

    // start request from the top level to the pair kernel
    typedef struct packed {
        logic                    start;
        logic                    zero;
        logic signed [POS_W-1:0] home_x;
        logic signed [POS_W-1:0] home_y;
        logic signed [POS_W-1:0] home_z;
        logic signed [CHG_W-1:0] home_charge;
        logic signed [POS_W-1:0] partner_x;
        logic signed [POS_W-1:0] partner_y;
        logic signed [POS_W-1:0] partner_z;
        logic signed [CHG_W-1:0] partner_charge;
    } pair_req_t;

    // result of the pair kernel, held until the next start
    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic signed [OUT_W-1:0] potential;
    } pair_res_t;

endpackage

// ===== design/cepc_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
module cepc_mul
    import cepc_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/cepc_core.sv =====
// pair kernel: sequencer around one multiplier, sqrt and divide steps
module cepc_core
    import cepc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pair_req_t req,
    output pair_res_t res
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PREP  = 5'd1;
    localparam logic [4:0] S_SQ    = 5'd2;
    localparam logic [4:0] S_SQEND = 5'd3;
    localparam logic [4:0] S_NORM  = 5'd4;
    localparam logic [4:0] S_SQRT  = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_INV2  = 5'd7;
    localparam logic [4:0] S_INV3  = 5'd8;
    localparam logic [4:0] S_ALO   = 5'd9;
    localparam logic [4:0] S_AHI   = 5'd10;
    localparam logic [4:0] S_AFIN  = 5'd11;
    localparam logic [4:0] S_FLO   = 5'd12;
    localparam logic [4:0] S_FHI   = 5'd13;
    localparam logic [4:0] S_FSUM  = 5'd14;
    localparam logic [4:0] S_FSAT  = 5'd15;
    localparam logic [4:0] S_PLO   = 5'd16;
    localparam logic [4:0] S_PHI   = 5'd17;
    localparam logic [4:0] S_PSUM  = 5'd18;
    localparam logic [4:0] S_PSAT  = 5'd19;
    localparam logic [4:0] S_DONE  = 5'd20;

    // sign * floor(p / 2^sh), saturated to 48 bits; negative sh shifts left
    function automatic logic [47:0] scale_sat(input logic neg, input logic [79:0] p,
                                              input logic signed [7:0] sh);
        logic [47:0] lim;
        logic [79:0] v;
        logic [47:0] mag;
        logic signed [7:0] nsh;
        lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        nsh = -sh;
        if (sh >= 8'sd0)
        begin
            v = p >> sh[6:0];
            mag = (v > {32'd0, lim}) ? lim : v[47:0];
        end
        else if (p == 80'd0)
        begin
            mag = 48'd0;
        end
        else if (p > ({32'd0, lim} >> nsh[3:0]))
        begin
            mag = lim;
        end
        else
        begin
            mag = p[47:0] << nsh[3:0];
        end
        return neg ? (48'd0 - mag) : mag;
    endfunction

    logic [4:0]  state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  m_reg, m_next;
    logic        s_reg, s_next;
    logic [31:0] mag_reg [3];
    logic [31:0] mag_next [3];
    logic [2:0]  dneg_reg, dneg_next;
    logic        qneg_reg, qneg_next;
    logic [23:0] qi_reg, qi_next;
    logic [23:0] qj_reg, qj_next;
    logic [46:0] qmag_reg, qmag_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] inv1_reg, inv1_next;
    logic [31:0] inv3_reg, inv3_next;
    logic [47:0] a_reg, a_next;
    logic [79:0] acc_reg, acc_next;
    logic [47:0] f_reg [3];
    logic [47:0] f_next [3];
    logic [47:0] pot_reg, pot_next;

    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    logic signed [32:0] d [3];
    logic [63:0] sq_t;
    logic [32:0] div_t;
    logic [63:0] a_full;
    logic [7:0]  sh_f, sh_p;

    cepc_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign d[0] = {req.home_x[31], req.home_x} - {req.partner_x[31], req.partner_x};
    assign d[1] = {req.home_y[31], req.home_y} - {req.partner_y[31], req.partner_y};
    assign d[2] = {req.home_z[31], req.home_z} - {req.partner_z[31], req.partner_z};

    assign sq_t   = res_reg + bit_reg;
    assign div_t  = {rem_reg, 1'b1};
    assign a_full = acc_reg[63:0] + {prod[31:0], 32'd0};
    assign sh_f   = 8'd85 + {6'd0, s_reg, 1'b0} - {2'd0, m_reg, 1'b0} - {3'd0, m_reg};
    assign sh_p   = 8'd55 + {7'd0, s_reg} - {3'd0, m_reg};

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = 32'd0;
        op_b = 32'd0;
        case (state_reg)
            S_PREP:
            begin
                op_a = {8'd0, qi_reg};
                op_b = {8'd0, qj_reg};
            end
            S_SQ:
            begin
                op_a = mag_reg[k_reg];
                op_b = mag_reg[k_reg];
            end
            S_INV2:
            begin
                op_a = inv1_reg;
                op_b = inv1_reg;
            end
            S_INV3:
            begin
                op_a = prod[63:32];
                op_b = inv1_reg;
            end
            S_ALO:
            begin
                op_a = qmag_reg[31:0];
                op_b = prod[63:32];
            end
            S_AHI:
            begin
                op_a = {17'd0, qmag_reg[46:32]};
                op_b = inv3_reg;
            end
            S_FLO:
            begin
                op_a = a_reg[31:0];
                op_b = mag_reg[k_reg];
            end
            S_FHI:
            begin
                op_a = {16'd0, a_reg[47:32]};
                op_b = mag_reg[k_reg];
            end
            S_PLO:
            begin
                op_a = qmag_reg[31:0];
                op_b = inv1_reg;
            end
            S_PHI:
            begin
                op_a = {17'd0, qmag_reg[46:32]};
                op_b = inv1_reg;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        s_next     = s_reg;
        mag_next   = mag_reg;
        dneg_next  = dneg_reg;
        qneg_next  = qneg_reg;
        qi_next    = qi_reg;
        qj_next    = qj_reg;
        qmag_next  = qmag_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        inv1_next  = inv1_reg;
        inv3_next  = inv3_reg;
        a_next     = a_reg;
        acc_next   = acc_reg;
        f_next     = f_reg;
        pot_next   = pot_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dneg_next[i] = d[i][32];
                        mag_next[i]  = d[i][32] ? 32'(-d[i]) : d[i][31:0];
                    end
                    qi_next   = req.home_charge[23] ? 24'(-req.home_charge) : req.home_charge;
                    qj_next   = req.partner_charge[23] ? 24'(-req.partner_charge)
                                                       : req.partner_charge;
                    qneg_next = req.home_charge[23] ^ req.partner_charge[23];
                    for (int i = 0; i < 3; i++)
                    begin
                        f_next[i] = 48'd0;
                    end
                    pot_next   = 48'd0;
                    state_next = req.zero ? S_DONE : S_PREP;
                end
            end
            S_PREP:
            begin
                // halve all components if any difference reaches 2^31
                s_next = mag_reg[0][31] | mag_reg[1][31] | mag_reg[2][31];
                for (int i = 0; i < 3; i++)
                begin
                    mag_next[i] = s_next ? (mag_reg[i] >> 1) : mag_reg[i];
                end
                x_next     = 64'd0;
                m_next     = 5'd0;
                k_next     = 2'd0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                if (k_reg == 2'd0)
                begin
                    qmag_next = prod[46:0];
                end
                else
                begin
                    x_next = x_reg + prod;
                end
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = S_SQEND;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_SQEND:
            begin
                x_next     = x_reg + prod;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (x_reg == 64'd0)
                begin
                    state_next = S_DONE;
                end
                else if (x_reg[63:62] == 2'b00)
                begin
                    x_next = x_reg << 2;
                    m_next = m_reg + 5'd1;
                end
                else
                begin
                    res_next   = 64'd0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (x_reg >= sq_t)
                begin
                    x_next   = x_reg - sq_t;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    rem_next   = 32'h7FFF_FFFF;
                    inv1_next  = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit of (2^63-1)/root per cycle
                if (div_t >= {1'b0, res_reg[31:0]})
                begin
                    rem_next  = 32'(div_t - {1'b0, res_reg[31:0]});
                    inv1_next = {inv1_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = div_t[31:0];
                    inv1_next = {inv1_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_INV2;
                end
            end
            S_INV2:
            begin
                state_next = S_INV3;
            end
            S_INV3:
            begin
                state_next = S_ALO;
            end
            S_ALO:
            begin
                inv3_next  = prod[63:32];
                state_next = S_AHI;
            end
            S_AHI:
            begin
                acc_next   = {16'd0, prod};
                state_next = S_AFIN;
            end
            S_AFIN:
            begin
                // product is kept modulo 2^64 before dropping 16 bits
                a_next     = a_full[63:16];
                k_next     = 2'd0;
                state_next = S_FLO;
            end
            S_FLO:
            begin
                state_next = S_FHI;
            end
            S_FHI:
            begin
                acc_next   = {16'd0, prod};
                state_next = S_FSUM;
            end
            S_FSUM:
            begin
                acc_next   = acc_reg + {prod[47:0], 32'd0};
                state_next = S_FSAT;
            end
            S_FSAT:
            begin
                f_next[k_reg] = scale_sat(qneg_reg ^ dneg_reg[k_reg], acc_reg, $signed(sh_f));
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = S_PLO;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_FLO;
                end
            end
            S_PLO:
            begin
                state_next = S_PHI;
            end
            S_PHI:
            begin
                acc_next   = {16'd0, prod};
                state_next = S_PSUM;
            end
            S_PSUM:
            begin
                acc_next   = acc_reg + {prod[47:0], 32'd0};
                state_next = S_PSAT;
            end
            S_PSAT:
            begin
                pot_next   = scale_sat(qneg_reg, acc_reg, $signed(sh_p));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 2'd0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        s_reg    <= s_next;
        mag_reg  <= mag_next;
        dneg_reg <= dneg_next;
        qneg_reg <= qneg_next;
        qi_reg   <= qi_next;
        qj_reg   <= qj_next;
        qmag_reg <= qmag_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        inv1_reg <= inv1_next;
        inv3_reg <= inv3_next;
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        f_reg    <= f_next;
        pot_reg  <= pot_next;
    end

    assign res.done      = (state_reg == S_DONE);
    assign res.force_x   = f_reg[0];
    assign res.force_y   = f_reg[1];
    assign res.force_z   = f_reg[2];
    assign res.potential = pot_reg;

endmodule

// ===== design/coulomb_exclusion_pair_correction.sv =====
// Coulomb exclusion pair correction: one excluded atom pair per input word.
// The input channel takes one pair word (positions, charges, indexes, last
// flag); in_stall stays high from acceptance until every result word of that
// pair has been taken, so one pair is in work at a time.
// Force mode gives one word per pair (the force on the partner) and, on the
// last pair, a second word with the negated force total of the home atom.
// Potential mode gives one word only on the last pair: the negated potential.
// In the pair kernel r^2 takes m (0..31) two-bit normalization steps;
// the 32-step square root and the 32-step reciprocal divide dominate.
// A zero distance skips the square root and the divide.
// The first result word holds while out_stall is high; the home total
// follows, loaded in the T_TOTAL state, once the partner word is taken.
// The next input word can be taken in the cycle after the last result
// word of the pair is taken. Reset clears the mode register (force mode),
// the running sums and all handshakes. Mode is written over the APB port
// at address 0, by the user only while idle; the block does not enforce this.
module coulomb_exclusion_pair_correction
    import cepc_pkg::*;
#(
    parameter int unsigned MAX_ATOMS = 65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_BUSY  = 3'd1;
    localparam logic [2:0] T_WAIT1 = 3'd2;
    localparam logic [2:0] T_TOTAL = 3'd3;
    localparam logic [2:0] T_WAIT2 = 3'd4;

    localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

    function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47])
        begin
            return s[48] ? NEG_LIM : POS_LIM;
        end
        return s[47:0];
    endfunction

    function automatic logic [47:0] neg_sat(input logic [47:0] v);
        return (v == NEG_LIM) ? POS_LIM : (48'd0 - v);
    endfunction

    logic [2:0]       state_reg, state_next;
    logic             mode_reg, mode_next;
    logic             item_mode_reg, item_mode_next;
    logic [15:0]      home_reg, home_next;
    logic [15:0]      partner_reg, partner_next;
    logic             last_reg, last_next;
    logic [47:0]      sfx_reg, sfx_next;
    logic [47:0]      sfy_reg, sfy_next;
    logic [47:0]      sfz_reg, sfz_next;
    logic [47:0]      spot_reg, spot_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    logic             in_take;
    logic             out_take;
    logic             cfg_write;
    pair_req_t        req;
    pair_res_t        res;

    assign in_take   = in_valid && (state_reg == T_IDLE);
    assign out_take  = out_valid_reg && !out_stall;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODE);

    assign req.start          = in_take;
    assign req.zero           = !(32'(in_data.partner_index) < MAX_ATOMS);
    assign req.home_x         = in_data.home_x;
    assign req.home_y         = in_data.home_y;
    assign req.home_z         = in_data.home_z;
    assign req.home_charge    = in_data.home_charge;
    assign req.partner_x      = in_data.partner_x;
    assign req.partner_y      = in_data.partner_y;
    assign req.partner_z      = in_data.partner_z;
    assign req.partner_charge = in_data.partner_charge;

    cepc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = cfg_write ? pwdata[0] : mode_reg;
        item_mode_next = item_mode_reg;
        home_next      = home_reg;
        partner_next   = partner_reg;
        last_next      = last_reg;
        sfx_next       = sfx_reg;
        sfy_next       = sfy_reg;
        sfz_next       = sfz_reg;
        spot_next      = spot_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_take)
                begin
                    item_mode_next = mode_reg;
                    home_next      = in_data.home_index;
                    partner_next   = in_data.partner_index;
                    last_next      = in_data.last_pair;
                    state_next     = T_BUSY;
                end
            end
            T_BUSY:
            begin
                if (res.done)
                begin
                    if (item_mode_reg == MODE_FORCE)
                    begin
                        sfx_next = add_sat(sfx_reg, res.force_x);
                        sfy_next = add_sat(sfy_reg, res.force_y);
                        sfz_next = add_sat(sfz_reg, res.force_z);
                        out_data_next.target_index  = partner_reg;
                        out_data_next.force_x       = res.force_x;
                        out_data_next.force_y       = res.force_y;
                        out_data_next.force_z       = res.force_z;
                        out_data_next.potential     = 48'd0;
                        out_data_next.is_home_total = 1'b0;
                        out_data_next.run_end       = !last_reg;
                        out_valid_next = 1'b1;
                        state_next     = T_WAIT1;
                    end
                    else
                    begin
                        spot_next  = add_sat(spot_reg, res.potential);
                        state_next = last_reg ? T_TOTAL : T_IDLE;
                    end
                end
            end
            T_WAIT1:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    state_next     = last_reg ? T_TOTAL : T_IDLE;
                end
            end
            T_TOTAL:
            begin
                // home total of the run, then the sums start over
                out_data_next.target_index  = home_reg;
                out_data_next.is_home_total = 1'b1;
                out_data_next.run_end       = 1'b1;
                if (item_mode_reg == MODE_FORCE)
                begin
                    out_data_next.force_x   = neg_sat(sfx_reg);
                    out_data_next.force_y   = neg_sat(sfy_reg);
                    out_data_next.force_z   = neg_sat(sfz_reg);
                    out_data_next.potential = 48'd0;
                end
                else
                begin
                    out_data_next.force_x   = 48'd0;
                    out_data_next.force_y   = 48'd0;
                    out_data_next.force_z   = 48'd0;
                    out_data_next.potential = neg_sat(spot_reg);
                end
                sfx_next       = 48'd0;
                sfy_next       = 48'd0;
                sfz_next       = 48'd0;
                spot_next      = 48'd0;
                out_valid_next = 1'b1;
                state_next     = T_WAIT2;
            end
            T_WAIT2:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b0;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            mode_reg      <= MODE_FORCE;
            sfx_reg       <= 48'd0;
            sfy_reg       <= 48'd0;
            sfz_reg       <= 48'd0;
            spot_reg      <= 48'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            sfx_reg       <= sfx_next;
            sfy_reg       <= sfy_next;
            sfz_reg       <= sfz_next;
            spot_reg      <= spot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_mode_reg <= item_mode_next;
        home_reg      <= home_next;
        partner_reg   <= partner_next;
        last_reg      <= last_next;
        out_data_reg  <= out_data_next;
    end

    assign in_stall  = (state_reg != T_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MODE) ? {{(PDATA_W-1){1'b0}}, mode_reg}
                                              : {PDATA_W{1'b0}};

    // a home total always closes the run of words of its pair
    a_total_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.is_home_total |-> out_data_reg.run_end)
        else $error("home total word without run end");

    // the kernel only finishes while the control waits for it
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> state_reg == T_BUSY)
        else $error("pair kernel finished outside busy state");

    // sums are cleared once the total word is loaded
    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_TOTAL |=> sfx_reg == 48'd0 && sfy_reg == 48'd0
                                 && sfz_reg == 48'd0 && spot_reg == 48'd0)
        else $error("sums not cleared after home total");

    // no word is offered while a pair is still being evaluated
    a_no_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == T_BUSY || state_reg == T_IDLE |-> !out_valid_reg)
        else $error("output valid while no result is pending");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the coulomb exclusion pair correction block
module tb_top;
    import cepc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ATOM_LIMIT = 65536;
    localparam longint POS_MAX = 64'sh7FFFFFFFFFFF;
    localparam longint NEG_MAX = -64'sh800000000000;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 160;
    localparam int IN_W = $bits(in_word_t);

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_word_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_word_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    in_word_t  pending_pairs[$];
    out_word_t expected_words[$];

    logic   cur_mode;
    longint acc_fx, acc_fy, acc_fz, acc_pot;
    int     error_count;
    int     cycle_count;
    int     in_gap;
    int     out_gap;
    bit     idling_on;

    coulomb_exclusion_pair_correction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit [63:0] floor_sqrt(bit [63:0] x);
        bit [63:0] res;
        bit [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // sign * floor(a*b * 2^-sh), clamped to 48 bits
    function automatic longint scaled_clamp(bit neg, bit [63:0] a, bit [63:0] b, int sh);
        bit [127:0] prod;
        bit [127:0] v;
        bit [63:0]  lim;
        int         k;
        prod = {64'd0, a} * {64'd0, b};
        lim = neg ? 64'h800000000000 : 64'h7FFFFFFFFFFF;
        if (sh >= 0)
            v = (sh >= 128) ? 128'd0 : (prod >> sh);
        else
        begin
            k = -sh;
            if (prod == 0)
                return 0;
            if (prod[127:64] != 0 || k >= 47 || prod[63:0] > (lim >> k))
                v = {64'd0, lim};
            else
                v = prod << k;
        end
        if (v > {64'd0, lim})
            v = {64'd0, lim};
        return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
    endfunction

    function automatic longint add_clamp(longint a, longint b);
        longint s;
        s = a + b;
        if (s > POS_MAX)
            return POS_MAX;
        if (s < NEG_MAX)
            return NEG_MAX;
        return s;
    endfunction

    function automatic longint negate_clamp(longint v);
        return (v <= NEG_MAX) ? POS_MAX : -v;
    endfunction

    // force components and pair potential of one excluded pair
    task automatic pair_interaction(input in_word_t w, output longint f[3], output longint pot);
        longint    delta;
        longint    q;
        bit [63:0] mag[3];
        bit        dneg[3];
        bit [63:0] r2, x, root, inv1, inv2, inv3, qmag, amp;
        bit        qneg;
        int        s, m;
        longint    hp[3], pp[3];
        hp[0] = longint'(w.home_x);
        hp[1] = longint'(w.home_y);
        hp[2] = longint'(w.home_z);
        pp[0] = longint'(w.partner_x);
        pp[1] = longint'(w.partner_y);
        pp[2] = longint'(w.partner_z);
        f[0] = 0;
        f[1] = 0;
        f[2] = 0;
        pot = 0;
        if (w.partner_index >= ATOM_LIMIT)
            return;
        q = longint'(w.home_charge) * longint'(w.partner_charge);
        qneg = q < 0;
        s = 0;
        for (int k = 0; k < 3; k++)
        begin
            delta = hp[k] - pp[k];
            dneg[k] = delta < 0;
            mag[k] = dneg[k] ? -delta : delta;
            if (mag[k] >= 64'h80000000)
                s = 1;
        end
        r2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = mag[k] >> s;
            r2 = r2 + mag[k] * mag[k];
        end
        if (r2 == 0)
            return;
        x = r2;
        m = 0;
        while (x < 64'h4000000000000000)
        begin
            x = x << 2;
            m++;
        end
        root = floor_sqrt(x);
        inv1 = 64'h7FFFFFFFFFFFFFFF / root;
        inv2 = (inv1 * inv1) >> 32;
        inv3 = (inv2 * inv1) >> 32;
        qmag = qneg ? -q : q;
        amp = (qmag * inv3) >> 16;
        for (int k = 0; k < 3; k++)
            f[k] = scaled_clamp(qneg != dneg[k], amp, mag[k], 85 + 2 * s - 3 * m);
        pot = scaled_clamp(qneg, qmag, inv1, 55 + s - m);
    endtask

    function automatic out_word_t make_word(logic [15:0] idx, longint fx, longint fy,
                                            longint fz, longint pot, logic home, logic fin);
        out_word_t o;
        o.target_index = idx;
        o.force_x = fx[47:0];
        o.force_y = fy[47:0];
        o.force_z = fz[47:0];
        o.potential = pot[47:0];
        o.is_home_total = home;
        o.run_end = fin;
        return o;
    endfunction

    task automatic predict_pair_words(input in_word_t w);
        longint f[3];
        longint pot;
        pair_interaction(w, f, pot);
        if (cur_mode == MODE_FORCE)
        begin
            acc_fx = add_clamp(acc_fx, f[0]);
            acc_fy = add_clamp(acc_fy, f[1]);
            acc_fz = add_clamp(acc_fz, f[2]);
            expected_words.push_back(make_word(w.partner_index, f[0], f[1], f[2], 0,
                                               1'b0, !w.last_pair));
            if (w.last_pair)
                expected_words.push_back(make_word(w.home_index, negate_clamp(acc_fx),
                    negate_clamp(acc_fy), negate_clamp(acc_fz), 0, 1'b1, 1'b1));
        end
        else
        begin
            acc_pot = add_clamp(acc_pot, pot);
            if (w.last_pair)
                expected_words.push_back(make_word(w.home_index, 0, 0, 0,
                    negate_clamp(acc_pot), 1'b1, 1'b1));
        end
        if (w.last_pair)
        begin
            acc_fx = 0;
            acc_fy = 0;
            acc_fz = 0;
            acc_pot = 0;
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_pair_words(in_data);
            if (in_valid && in_stall)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                in_data <= pending_pairs.pop_front();
                in_valid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and stall generator
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, out_data);
                    error_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_data.target_index !== exp_w.target_index)
                    begin
                        $display("%0t: target_index expected %0d got %0d", $time,
                                 exp_w.target_index, out_data.target_index);
                        error_count++;
                    end
                    if (out_data.force_x !== exp_w.force_x)
                    begin
                        $display("%0t: force_x expected %0d got %0d", $time,
                                 exp_w.force_x, out_data.force_x);
                        error_count++;
                    end
                    if (out_data.force_y !== exp_w.force_y)
                    begin
                        $display("%0t: force_y expected %0d got %0d", $time,
                                 exp_w.force_y, out_data.force_y);
                        error_count++;
                    end
                    if (out_data.force_z !== exp_w.force_z)
                    begin
                        $display("%0t: force_z expected %0d got %0d", $time,
                                 exp_w.force_z, out_data.force_z);
                        error_count++;
                    end
                    if (out_data.potential !== exp_w.potential)
                    begin
                        $display("%0t: potential expected %0d got %0d", $time,
                                 exp_w.potential, out_data.potential);
                        error_count++;
                    end
                    if (out_data.is_home_total !== exp_w.is_home_total)
                    begin
                        $display("%0t: is_home_total expected %0b got %0b", $time,
                                 exp_w.is_home_total, out_data.is_home_total);
                        error_count++;
                    end
                    if (out_data.run_end !== exp_w.run_end)
                    begin
                        $display("%0t: run_end expected %0b got %0b", $time,
                                 exp_w.run_end, out_data.run_end);
                        error_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("coulomb_exclusion_pair_correction regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input int index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(index * 4);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == int'(REG_MODE))
            cur_mode = value[0];
    endtask

    task automatic set_mode(input logic md);
        reg_write(int'(REG_MODE), {$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'd1 | md);
    endtask

    // wait until every word is taken and the kernel has settled
    task automatic drain();
        while (pending_pairs.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic in_word_t pair_word(logic [15:0] home, logic [15:0] partner,
            longint hx, longint hy, longint hz, longint qh,
            longint px, longint py, longint pz, longint qp, logic fin);
        in_word_t w;
        w.home_index = home;
        w.partner_index = partner;
        w.home_x = hx[31:0];
        w.home_y = hy[31:0];
        w.home_z = hz[31:0];
        w.home_charge = qh[23:0];
        w.partner_x = px[31:0];
        w.partner_y = py[31:0];
        w.partner_z = pz[31:0];
        w.partner_charge = qp[23:0];
        w.last_pair = fin;
        return w;
    endfunction

    function automatic logic [31:0] near_offset(logic [31:0] base);
        logic [31:0] dlt;
        dlt = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? base + dlt : base - dlt;
    endfunction

    function automatic logic [23:0] rand_charge();
        return $urandom_range(0, 3) == 0 ? 24'($urandom())
               : 24'($signed($urandom_range(0, 400)) - 200) << $urandom_range(0, 14);
    endfunction

    function automatic in_word_t rand_pair(logic [15:0] home, logic fin);
        in_word_t w;
        w = $urandom_range(0, 9) == 0 ? in_word_t'(IN_W'({$urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()})) : '0;
        w.home_index = home;
        w.partner_index = 16'($urandom());
        w.last_pair = fin;
        if ($urandom_range(0, 9) != 0)
        begin
            w.home_x = $urandom();
            w.home_y = $urandom();
            w.home_z = $urandom();
            w.home_charge = rand_charge();
            w.partner_charge = rand_charge();
            case ($urandom_range(0, 3))
                0: begin
                    w.partner_x = w.home_x;
                    w.partner_y = w.home_y;
                    w.partner_z = w.home_z;
                end
                1: begin
                    w.partner_x = $urandom();
                    w.partner_y = $urandom();
                    w.partner_z = $urandom();
                end
                default: begin
                    w.partner_x = near_offset(w.home_x);
                    w.partner_y = near_offset(w.home_y);
                    w.partner_z = near_offset(w.home_z);
                end
            endcase
            if ($urandom_range(0, 30) == 0)
            begin
                w.partner_x = w.home_x;
                w.partner_y = w.home_y;
                w.partner_z = w.home_z;
            end
        end
        return w;
    endfunction

    task automatic queue_directed();
        longint pmax, pmin, qmax, qmin;
        pmax = 64'sh7FFFFFFF;
        pmin = -64'sh80000000;
        qmax = 64'sh7FFFFF;
        qmin = -64'sh800000;
        // opposite corners, shifted distance
        pending_pairs.push_back(pair_word(16'hFFFF, 16'h0000, pmax, pmax, pmax, qmax,
                                          pmin, pmin, pmin, qmax, 1'b0));
        pending_pairs.push_back(pair_word(16'hFFFF, 16'hFFFF, pmin, pmax, pmin, qmin,
                                          pmax, pmin, pmax, qmin, 1'b0));
        pending_pairs.push_back(pair_word(16'hFFFF, 16'h1234, pmin, 0, pmax, qmin,
                                          pmax, 0, pmin, qmax, 1'b1));
        // zero distance
        pending_pairs.push_back(pair_word(16'h0000, 16'h0001, 12345, -6789, 5, qmax,
                                          12345, -6789, 5, qmin, 1'b0));
        // one lsb apart: huge force, saturates
        pending_pairs.push_back(pair_word(16'h0000, 16'h0002, 0, 0, 0, qmin,
                                          1, 0, 0, qmin, 1'b0));
        pending_pairs.push_back(pair_word(16'h0000, 16'h0003, 0, 0, 0, qmin,
                                          0, -1, 0, qmin, 1'b0));
        pending_pairs.push_back(pair_word(16'h0000, 16'h0004, 0, 0, 0, qmax,
                                          0, 0, 1, qmin, 1'b1));
        // sums pushed to the positive limit then negated
        pending_pairs.push_back(pair_word(16'h0007, 16'h0005, 0, 0, 0, qmin,
                                          -1, -1, -1, qmin, 1'b0));
        pending_pairs.push_back(pair_word(16'h0007, 16'h0006, 0, 0, 0, qmin,
                                          -1, -1, -1, qmin, 1'b1));
        // unit distance, unit charges, zero charge
        pending_pairs.push_back(pair_word(16'h0010, 16'h0011, 64'sh10000, 0, 0, 64'sh10000,
                                          0, 0, 0, 64'sh10000, 1'b0));
        pending_pairs.push_back(pair_word(16'h0010, 16'h0012, 0, 0, 0, 0,
                                          64'sh30000, 64'sh40000, 0, qmax, 1'b1));
    endtask

    initial
    begin
        int run_len;
        int left;
        logic [15:0] home;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_mode = MODE_FORCE;
        acc_fx = 0;
        acc_fy = 0;
        acc_fz = 0;
        acc_pot = 0;
        error_count = 0;
        cycle_count = 0;
        in_gap = 0;
        out_gap = 0;
        idling_on = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed pairs in force mode from reset, then in potential mode
        queue_directed();
        drain();
        set_mode(MODE_POTENTIAL);
        queue_directed();
        drain();
        // unmapped register: ignored, mode stays potential
        reg_write(1, 32'hFFFFFFFF);
        pending_pairs.push_back(rand_pair(16'h0042, 1'b1));
        drain();
        set_mode(MODE_FORCE);

        for (int ph = 0; ph < 6; ph++)
        begin
            idling_on = (ph < 5);
            if (ph > 0)
                set_mode(ph % 2 == 1 ? MODE_POTENTIAL : MODE_FORCE);
            left = 140;
            while (left > 0)
            begin
                // mostly well-formed exclusion lists, some broken ones
                run_len = $urandom_range(1, 8);
                home = 16'($urandom());
                for (int k = 0; k < run_len && left > 0; k++, left--)
                begin
                    if ($urandom_range(0, 9) == 0)
                        pending_pairs.push_back(rand_pair(16'($urandom()),
                                                          1'($urandom_range(0, 1))));
                    else
                        pending_pairs.push_back(rand_pair(home, k == run_len - 1));
                end
            end
            // odd phases may leave a run open so sums carry across the mode change
            if (ph % 2 == 0)
                pending_pairs.push_back(rand_pair(home, 1'b1));
            drain();
        end

        if (error_count == 0)
            $display("coulomb_exclusion_pair_correction regression: pass");
        else
            $display("coulomb_exclusion_pair_correction regression: fail");
        $finish;
    end

endmodule
